/* sv/smx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int WORD_W      = 32;
    localparam int OP_W        = 4;
    localparam int DEPTH_OUT_W = 7;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 4'd0;
    localparam logic [OP_W-1:0] OP_DUP  = 4'd1;
    localparam logic [OP_W-1:0] OP_DROP = 4'd2;
    localparam logic [OP_W-1:0] OP_SWAP = 4'd3;
    localparam logic [OP_W-1:0] OP_ROT  = 4'd4;
    localparam logic [OP_W-1:0] OP_ADD  = 4'd5;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd8;
    localparam logic [OP_W-1:0] OP_NEG  = 4'd9;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_DIVZ  = 2'd3
    } smx_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_DIV,
        S_WR0,
        S_WR1,
        S_WR2,
        S_OUT
    } smx_state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } smx_div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } smx_div_rsp_t;

    // operand count an opcode takes from the stack
    function automatic logic [1:0] need_count(input logic [OP_W-1:0] op);
        logic [1:0] n;
        n = 2'd0;
        unique case (op)
            OP_DUP, OP_DROP, OP_NEG:                 n = 2'd1;
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV: n = 2'd2;
            OP_ROT:                                  n = 2'd3;
            default:                                 n = 2'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

/* sv/smx_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* sv/smx_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module smx_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire smx_pkg::smx_div_req_t req,
    output      smx_pkg::smx_div_rsp_t rsp
);

    localparam int W   = smx_pkg::WORD_W;
    localparam int CW  = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic          neg_reg, neg_next;

    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.num[W-1] ? (W'(0) - req.num) : req.num;
            den_next  = req.den[W-1] ? (W'(0) - req.den) : req.den;
            neg_next  = req.num[W-1] ^ req.den[W-1];
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule
`default_nettype wire

/* sv/stack_machine_executor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack instruction per input word on a 32-bit data stack.
// ----------------------------------------------------------------------------
// Input channel s_*: one instruction per word, opcode in s_tuser, push value
// in s_tdata. Output channel m_*: one word per instruction with the new top
// of stack, depth and status. Refused instructions leave the stack as is.
// The stack lives in a RAM with a registered read port; the top entry is
// mirrored in a register. Words are handled one at a time; after S_IDLE each
// runs the states its opcode needs, S_DIV waiting on the radix-2 divider:
//   refused or unused opcode  S_OUT
//   push, dup, negate         S_WR0, S_OUT
//   drop, add, sub, mul       S_RD0, S_RD1, S_WR0, S_OUT
//   swap                      S_RD0, S_RD1, S_WR0, S_WR1, S_OUT
//   rot                       S_RD0 to S_RD2, S_WR0 to S_WR2, S_OUT
//   div                       S_RD0, S_RD1, S_DIV, S_WR0, S_OUT
// The RAM gives one access of each kind per cycle. Results sit in an output
// register; s_tready drops while an instruction is in flight and while a
// finished result waits on a stalled m_tready. Reset empties the stack and
// clears the output valid; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] immediate
    input  wire logic [3:0]  s_tuser,   // [3:0] operation
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [47:0] m_tdata    // [31:0] top_value, [38:32] depth,
                                        // [40:39] status, [47:41] zero
);

    localparam int W  = smx_pkg::WORD_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int OW = smx_pkg::DEPTH_OUT_W;

    smx_pkg::smx_state_t  state_reg, state_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [W-1:0]         top_reg, top_next;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         b_reg, b_next;
    logic [smx_pkg::OP_W-1:0] op_reg, op_next;
    logic [W-1:0]         imm_reg, imm_next;
    smx_pkg::smx_status_t stat_reg, stat_next;
    logic                 m_valid_reg, m_valid_next;
    logic [47:0]          m_data_reg, m_data_next;

    logic                 accept;
    logic                 out_free;
    smx_pkg::smx_status_t acc_status;
    logic                 acc_known;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [W-1:0]         wr_data;
    logic [AW-1:0]        rd_addr;
    logic [W-1:0]         rd_data;

    smx_pkg::smx_div_req_t div_req;
    smx_pkg::smx_div_rsp_t div_rsp;

    logic [AW-1:0]        d_lo;
    logic [W-1:0]         arith;
    logic [DW+OW-1:0]     depth_ext;
    logic [W-1:0]         top_out;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign d_lo     = depth_reg[AW-1:0];
    assign acc_known = (s_tuser <= smx_pkg::OP_NEG);

    always_comb begin
        acc_status = smx_pkg::STAT_OK;
        if (acc_known) begin
            if (depth_reg < DW'(smx_pkg::need_count(s_tuser))) begin
                acc_status = smx_pkg::STAT_UNDER;
            end else if ((s_tuser == smx_pkg::OP_PUSH || s_tuser == smx_pkg::OP_DUP)
                         && depth_reg == DW'(STACK_DEPTH)) begin
                acc_status = smx_pkg::STAT_OVER;
            end else if (s_tuser == smx_pkg::OP_DIV && top_reg == '0) begin
                acc_status = smx_pkg::STAT_DIVZ;
            end
        end
    end

    always_comb begin
        case (op_reg)
            smx_pkg::OP_ADD: arith = b_reg + top_reg;
            smx_pkg::OP_SUB: arith = b_reg - top_reg;
            smx_pkg::OP_MUL: arith = W'(b_reg * top_reg);
            default:         arith = div_rsp.quotient;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smx_pkg::S_IDLE: begin
                if (accept) begin
                    if (!acc_known || acc_status != smx_pkg::STAT_OK) begin
                        state_next = smx_pkg::S_OUT;
                    end else if (s_tuser == smx_pkg::OP_PUSH || s_tuser == smx_pkg::OP_DUP
                                 || s_tuser == smx_pkg::OP_NEG) begin
                        state_next = smx_pkg::S_WR0;
                    end else begin
                        state_next = smx_pkg::S_RD0;
                    end
                end
            end
            smx_pkg::S_RD0: state_next = smx_pkg::S_RD1;
            smx_pkg::S_RD1: begin
                if (op_reg == smx_pkg::OP_ROT) begin
                    state_next = smx_pkg::S_RD2;
                end else if (op_reg == smx_pkg::OP_DIV) begin
                    state_next = smx_pkg::S_DIV;
                end else begin
                    state_next = smx_pkg::S_WR0;
                end
            end
            smx_pkg::S_RD2: state_next = smx_pkg::S_WR0;
            smx_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    state_next = smx_pkg::S_WR0;
                end
            end
            smx_pkg::S_WR0: begin
                if (op_reg == smx_pkg::OP_SWAP || op_reg == smx_pkg::OP_ROT) begin
                    state_next = smx_pkg::S_WR1;
                end else begin
                    state_next = smx_pkg::S_OUT;
                end
            end
            smx_pkg::S_WR1: begin
                if (op_reg == smx_pkg::OP_ROT) begin
                    state_next = smx_pkg::S_WR2;
                end else begin
                    state_next = smx_pkg::S_OUT;
                end
            end
            smx_pkg::S_WR2: state_next = smx_pkg::S_OUT;
            smx_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = smx_pkg::S_IDLE;
                end
            end
            default: state_next = smx_pkg::S_IDLE;
        endcase
    end

    assign depth_ext = {{OW{1'b0}}, depth_reg};
    assign top_out   = (depth_reg == '0) ? '0 : top_reg;

    // datapath and outputs
    always_comb begin
        s_tready     = (state_reg == smx_pkg::S_IDLE);
        depth_next   = depth_reg;
        top_next     = top_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        op_next      = op_reg;
        imm_next     = imm_reg;
        stat_next    = stat_reg;
        wr_en        = 1'b0;
        wr_addr      = d_lo - AW'(2);
        wr_data      = top_reg;
        rd_addr      = d_lo - AW'(2);
        div_req      = '{start: 1'b0, num: rd_data, den: top_reg};
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            smx_pkg::S_IDLE: begin
                if (accept) begin
                    op_next   = s_tuser;
                    imm_next  = s_tdata;
                    stat_next = acc_status;
                end
            end
            smx_pkg::S_RD0: begin
            end
            smx_pkg::S_RD1: begin
                rd_addr = d_lo - AW'(3);
                b_next  = rd_data;
                div_req.start = (op_reg == smx_pkg::OP_DIV);
            end
            smx_pkg::S_RD2: begin
                a_next = rd_data;
            end
            smx_pkg::S_DIV: begin
            end
            smx_pkg::S_WR0: begin
                case (op_reg)
                    smx_pkg::OP_PUSH: begin
                        wr_en      = 1'b1;
                        wr_addr    = d_lo;
                        wr_data    = imm_reg;
                        top_next   = imm_reg;
                        depth_next = depth_reg + DW'(1);
                    end
                    smx_pkg::OP_DUP: begin
                        wr_en      = 1'b1;
                        wr_addr    = d_lo;
                        depth_next = depth_reg + DW'(1);
                    end
                    smx_pkg::OP_NEG: begin
                        wr_en    = 1'b1;
                        wr_addr  = d_lo - AW'(1);
                        wr_data  = W'(0) - top_reg;
                        top_next = W'(0) - top_reg;
                    end
                    smx_pkg::OP_DROP: begin
                        top_next   = b_reg;
                        depth_next = depth_reg - DW'(1);
                    end
                    smx_pkg::OP_SWAP: begin
                        wr_en = 1'b1;
                    end
                    smx_pkg::OP_ROT: begin
                        wr_en   = 1'b1;
                        wr_addr = d_lo - AW'(3);
                        wr_data = b_reg;
                    end
                    default: begin
                        wr_en      = 1'b1;
                        wr_data    = arith;
                        top_next   = arith;
                        depth_next = depth_reg - DW'(1);
                    end
                endcase
            end
            smx_pkg::S_WR1: begin
                wr_en = 1'b1;
                if (op_reg == smx_pkg::OP_SWAP) begin
                    wr_addr  = d_lo - AW'(1);
                    wr_data  = b_reg;
                    top_next = b_reg;
                end
            end
            smx_pkg::S_WR2: begin
                wr_en    = 1'b1;
                wr_addr  = d_lo - AW'(1);
                wr_data  = a_reg;
                top_next = a_reg;
            end
            smx_pkg::S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, stat_reg, depth_ext[OW-1:0], top_out};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smx_pkg::S_IDLE;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg    <= top_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        op_reg     <= op_next;
        imm_reg    <= imm_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    smx_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule
`default_nettype wire

/* verif/stack_machine_executor_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_test
// Self-checking bench for the stack machine executor. A directed table
// covers empty-stack refusals, extreme values, divide by zero, the most
// negative value over minus one and the spare opcodes. Random instruction
// words follow, mostly well-formed, with bursts that fill the stack past
// its limit. Result words are checked against typed table rows, else a shadow
// stack running each accepted instruction. Both channels idle at random, the
// receiver holds off once for a long stretch, the sender drains between phases.
// ----------------------------------------------------------------------------
module stack_machine_executor_test;
    import smx_pkg::*;

    localparam int STACK_SLOTS       = 64;
    localparam int CLK_HALF          = 6;
    localparam int STALL_LIMIT       = 2000;
    localparam int LONG_HOLD         = 300;
    localparam int DRAIN_CYCLES      = 60;
    localparam int RANDOM_WORDS      = 125;
    localparam int REPORT_LIMIT      = 10;
    localparam int DIRECTED_COUNT    = 26;

    localparam logic [OP_W-1:0]   OP_SPARE_LO = 4'd10;
    localparam logic [OP_W-1:0]   OP_SPARE_HI = 4'd15;
    localparam logic [WORD_W-1:0] INT_MAX     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] INT_MIN     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] JUNK        = 32'hA5A5_5A5A;

    typedef struct packed {
        logic [WORD_W-1:0]      top;
        logic [DEPTH_OUT_W-1:0] depth;
        smx_status_t            status;
    } stack_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] imm;
        logic              typed;
        stack_result_t     want;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{OP_DROP,     JUNK,     1'b1, '{32'h0,       7'd0, STAT_UNDER}},
        '{OP_DUP,      JUNK,     1'b1, '{32'h0,       7'd0, STAT_UNDER}},
        '{OP_ROT,      JUNK,     1'b1, '{32'h0,       7'd0, STAT_UNDER}},
        '{OP_DIV,      JUNK,     1'b1, '{32'h0,       7'd0, STAT_UNDER}},
        '{OP_PUSH,     INT_MAX,  1'b1, '{INT_MAX,     7'd1, STAT_OK}},
        '{OP_SWAP,     JUNK,     1'b1, '{INT_MAX,     7'd1, STAT_UNDER}},
        '{OP_PUSH,     INT_MIN,  1'b1, '{INT_MIN,     7'd2, STAT_OK}},
        '{OP_ADD,      JUNK,     1'b1, '{ALL_ONES,    7'd1, STAT_OK}},
        '{OP_PUSH,     32'h0,    1'b1, '{32'h0,       7'd2, STAT_OK}},
        '{OP_DIV,      JUNK,     1'b1, '{32'h0,       7'd2, STAT_DIVZ}},
        '{OP_DROP,     JUNK,     1'b1, '{ALL_ONES,    7'd1, STAT_OK}},
        '{OP_NEG,      JUNK,     1'b1, '{32'h1,       7'd1, STAT_OK}},
        '{OP_PUSH,     INT_MIN,  1'b1, '{INT_MIN,     7'd2, STAT_OK}},
        '{OP_PUSH,     ALL_ONES, 1'b1, '{ALL_ONES,    7'd3, STAT_OK}},
        '{OP_DIV,      JUNK,     1'b1, '{INT_MIN,     7'd2, STAT_OK}},
        '{OP_ROT,      JUNK,     1'b1, '{INT_MIN,     7'd2, STAT_UNDER}},
        '{OP_PUSH,     32'h5,    1'b1, '{32'h5,       7'd3, STAT_OK}},
        '{OP_ROT,      JUNK,     1'b0, '0},
        '{OP_SWAP,     JUNK,     1'b0, '0},
        '{OP_SUB,      JUNK,     1'b0, '0},
        '{OP_MUL,      JUNK,     1'b0, '0},
        '{OP_NEG,      JUNK,     1'b0, '0},
        '{OP_SPARE_LO, INT_MAX,  1'b0, '0},
        '{OP_SPARE_HI, INT_MIN,  1'b0, '0},
        '{OP_PUSH,     INT_MIN,  1'b1, '{INT_MIN,     7'd2, STAT_OK}},
        '{OP_NEG,      JUNK,     1'b1, '{INT_MIN,     7'd2, STAT_OK}}
    };

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [31:0]       s_tdata  = '0;
    logic [3:0]        s_tuser  = '0;
    logic              m_tready = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [47:0]       m_tdata;

    logic [WORD_W-1:0] shadow_stack [STACK_SLOTS];
    int unsigned       shadow_depth = 0;
    stack_result_t     pending_results [$];

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    bit                hold_request  = 1'b0;
    int unsigned       hold_left     = 0;
    int unsigned       quiet_cycles  = 0;
    int unsigned       error_count   = 0;
    int unsigned       mismatch_count = 0;

    stack_machine_executor #(
        .STACK_DEPTH(STACK_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),     // [31:0] immediate
        .s_tuser (s_tuser),     // [3:0] operation
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)      // [31:0] top_value, [38:32] depth, [40:39] status
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic logic [WORD_W-1:0] quotient_toward_zero(
        input logic [WORD_W-1:0] num,
        input logic [WORD_W-1:0] den
    );
        logic [WORD_W-1:0] num_mag;
        logic [WORD_W-1:0] den_mag;
        logic [WORD_W-1:0] q;
        num_mag = num[WORD_W-1] ? -num : num;
        den_mag = den[WORD_W-1] ? -den : den;
        q = num_mag / den_mag;
        return (num[WORD_W-1] ^ den[WORD_W-1]) ? -q : q;
    endfunction

    task automatic execute_on_shadow(
        input  logic [OP_W-1:0]   op,
        input  logic [WORD_W-1:0] imm,
        output stack_result_t     res
    );
        int unsigned       need;
        int unsigned       d;
        smx_status_t       st;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        d  = shadow_depth;
        st = STAT_OK;
        case (op)
            OP_DUP, OP_DROP, OP_NEG:                 need = 1;
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV: need = 2;
            OP_ROT:                                  need = 3;
            default:                                 need = 0;
        endcase
        if (op <= OP_NEG) begin
            if (d < need) begin
                st = STAT_UNDER;
            end else if ((op == OP_PUSH || op == OP_DUP) && d >= STACK_SLOTS) begin
                st = STAT_OVER;
            end else if (op == OP_DIV && shadow_stack[d-1] == '0) begin
                st = STAT_DIVZ;
            end else begin
                case (op)
                    OP_PUSH: begin
                        shadow_stack[d] = imm;
                        d++;
                    end
                    OP_DUP: begin
                        shadow_stack[d] = shadow_stack[d-1];
                        d++;
                    end
                    OP_DROP: begin
                        d--;
                    end
                    OP_SWAP: begin
                        a = shadow_stack[d-2];
                        shadow_stack[d-2] = shadow_stack[d-1];
                        shadow_stack[d-1] = a;
                    end
                    OP_ROT: begin
                        a = shadow_stack[d-3];
                        shadow_stack[d-3] = shadow_stack[d-2];
                        shadow_stack[d-2] = shadow_stack[d-1];
                        shadow_stack[d-1] = a;
                    end
                    OP_NEG: begin
                        shadow_stack[d-1] = -shadow_stack[d-1];
                    end
                    default: begin
                        b = shadow_stack[d-2];
                        c = shadow_stack[d-1];
                        case (op)
                            OP_ADD:  a = b + c;
                            OP_SUB:  a = b - c;
                            OP_MUL:  a = b * c;
                            default: a = quotient_toward_zero(b, c);
                        endcase
                        shadow_stack[d-2] = a;
                        d--;
                    end
                endcase
                shadow_depth = d;
            end
        end
        res.top    = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth-1];
        res.depth  = DEPTH_OUT_W'(shadow_depth);
        res.status = st;
    endtask

    task automatic note_mismatch(
        input string             what,
        input logic [WORD_W-1:0] want,
        input logic [WORD_W-1:0] got
    );
        error_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%t %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    // offer one instruction word, record its expected result once accepted
    task automatic send_word(
        input logic [OP_W-1:0]   op,
        input logic [WORD_W-1:0] imm,
        input logic              typed,
        input stack_result_t     want
    );
        stack_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= imm;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        execute_on_shadow(op, imm, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_immediate;
        case ($urandom_range(7))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return '0;
            3:       return ALL_ONES;
            4, 5:    return WORD_W'($urandom_range(8)) - 32'd4;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_operation;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return OP_W'($urandom_range(15));
        if (shadow_depth < 3 && roll < 50)
            return OP_PUSH;
        roll = $urandom_range(99);
        if (roll < 30) return OP_PUSH;
        if (roll < 36) return OP_DUP;
        if (roll < 44) return OP_DROP;
        if (roll < 51) return OP_SWAP;
        if (roll < 58) return OP_ROT;
        if (roll < 65) return OP_ADD;
        if (roll < 72) return OP_SUB;
        if (roll < 79) return OP_MUL;
        if (roll < 91) return OP_DIV;
        return OP_NEG;
    endfunction

    // push until full, then a few more to hit the overflow refusal
    task automatic fill_stack;
        int unsigned extra;
        extra = 0;
        while (extra < 4) begin
            if (shadow_depth >= STACK_SLOTS)
                extra++;
            send_word(($urandom_range(4) == 0) ? OP_DUP : OP_PUSH, pick_immediate(),
                      1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        stack_result_t want;
        stack_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.top    = m_tdata[31:0];
            got.depth  = m_tdata[38:32];
            got.status = smx_status_t'(m_tdata[40:39]);
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected word", '0, m_tdata[31:0]);
            end else begin
                want = pending_results.pop_front();
                if (got.top != want.top)
                    note_mismatch("top_value", want.top, got.top);
                if (got.depth != want.depth)
                    note_mismatch("depth", WORD_W'(want.depth), WORD_W'(got.depth));
                if (got.status != want.status)
                    note_mismatch("status", WORD_W'(want.status), WORD_W'(got.status));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 16;
        recv_idle_pct = 78;
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].imm,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 16 : 0;
            for (int n = 0; n < RANDOM_WORDS; n++) begin
                if (n == 40 && phase != 1)
                    fill_stack();
                if (n == 60 && phase == 2)
                    hold_request = 1'b1;
                send_word(pick_operation(), pick_immediate(), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0d result words never arrived", pending_results.size());
        end
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/smx_pkg.sv
sv/smx_ram.sv
sv/smx_div.sv
sv/stack_machine_executor.sv
verif/stack_machine_executor_test.sv
